// File: hw/rtl/ebalu_pkg.sv
package ebalu_pkg;

  localparam logic [4:0] OP_ADD     = 5'd0;
  localparam logic [4:0] OP_ADC     = 5'd1;
  localparam logic [4:0] OP_SUB     = 5'd2;
  localparam logic [4:0] OP_SBC     = 5'd3;
  localparam logic [4:0] OP_AND     = 5'd4;
  localparam logic [4:0] OP_XOR     = 5'd5;
  localparam logic [4:0] OP_OR      = 5'd6;
  localparam logic [4:0] OP_CP      = 5'd7;
  localparam logic [4:0] OP_INC     = 5'd8;
  localparam logic [4:0] OP_DEC     = 5'd9;
  localparam logic [4:0] OP_RLC     = 5'd10;
  localparam logic [4:0] OP_RRC     = 5'd11;
  localparam logic [4:0] OP_RL      = 5'd12;
  localparam logic [4:0] OP_RR      = 5'd13;
  localparam logic [4:0] OP_SLA     = 5'd14;
  localparam logic [4:0] OP_SRA     = 5'd15;
  localparam logic [4:0] OP_SWAP    = 5'd16;
  localparam logic [4:0] OP_SRL     = 5'd17;
  localparam logic [4:0] OP_BIT     = 5'd18;
  localparam logic [4:0] OP_RES     = 5'd19;
  localparam logic [4:0] OP_SET     = 5'd20;
  localparam logic [4:0] OP_RLCA    = 5'd21;
  localparam logic [4:0] OP_RRCA    = 5'd22;
  localparam logic [4:0] OP_RLA     = 5'd23;
  localparam logic [4:0] OP_RRA     = 5'd24;
  localparam logic [4:0] OP_DAA     = 5'd25;
  localparam logic [4:0] OP_CPL     = 5'd26;
  localparam logic [4:0] OP_SCF     = 5'd27;
  localparam logic [4:0] OP_CCF     = 5'd28;
  localparam logic [4:0] OP_ADD16   = 5'd29;
  localparam logic [4:0] OP_ADD_OFF = 5'd30;

  // flag positions in a 4-bit flag word
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  localparam logic [7:0] DAA_HI_CORR = 8'h06 << 4;
  localparam logic [7:0] DAA_LO_CORR = 8'h06;
  localparam logic [7:0] DAA_LIMIT   = 8'h99;
  localparam logic [3:0] BCD_MAX     = 4'd9;

  // after the adder stage
  typedef struct packed {
    logic [4:0]  op;
    logic [7:0]  acc;
    logic [7:0]  operand;
    logic [2:0]  bit_index;
    logic [3:0]  flags;
    logic [7:0]  ar;
    logic        ah;
    logic        ac;
    logic [7:0]  ir;
    logic        ih;
    logic [7:0]  dr;
    logic        dc;
    logic [15:0] w;
    logic        wh;
    logic        wc;
  } s1_t;

  // after the select stage
  typedef struct packed {
    logic [7:0]  r;
    logic [15:0] w;
    logic [7:0]  zsrc;
    logic        zcalc;
    logic        zfix;
    logic        n;
    logic        h;
    logic        c;
  } s2_t;

endpackage

// File: hw/rtl/eight_bit_alu_with_flags.sv
// Eight-bit ALU with Z/N/H/C flags. A request is taken whenever start is high;
// busy is always low, so a new request may be issued every cycle. Each request
// gives exactly one result, after the three register stages (adders, result
// select, flag assembly), on result, wide_result and flags_out, marked by done
// for one cycle; results leave in request order. The receiver cannot stall the
// pipeline and must take every result.
module eight_bit_alu_with_flags
  import ebalu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [4:0]        op,
  input  logic [7:0]        acc,
  input  logic [7:0]        operand,
  input  logic [2:0]        bit_index,
  input  logic [3:0]        flags_in,
  input  logic [15:0]       wide_a,
  input  logic [15:0]       wide_b,
  input  logic signed [7:0] offset,
  output logic              done,
  output logic [7:0]        result,
  output logic [15:0]       wide_result,
  output logic [3:0]        flags_out
);

  logic accept;
  logic v1;
  logic v2;
  s1_t  d1;
  s2_t  d2;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  ebalu_arith u_arith (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .op        (op),
    .acc       (acc),
    .operand   (operand),
    .bit_index (bit_index),
    .flags_in  (flags_in),
    .wide_a    (wide_a),
    .wide_b    (wide_b),
    .offset    (offset),
    .out_valid (v1),
    .out_data  (d1)
  );

  ebalu_select u_select (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_data   (d1),
    .out_valid (v2),
    .out_data  (d2)
  );

  ebalu_flags u_flags (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (v2),
    .in_data     (d2),
    .out_valid   (done),
    .result      (result),
    .wide_result (wide_result),
    .flags_out   (flags_out)
  );

endmodule

// File: hw/rtl/ebalu_arith.sv
module ebalu_arith
  import ebalu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [4:0]        op,
  input  logic [7:0]        acc,
  input  logic [7:0]        operand,
  input  logic [2:0]        bit_index,
  input  logic [3:0]        flags_in,
  input  logic [15:0]       wide_a,
  input  logic [15:0]       wide_b,
  input  logic signed [7:0] offset,
  output logic              out_valid,
  output s1_t               out_data
);

  s1_t         s_next;
  logic        cin;
  logic        is_sub;
  logic [8:0]  sum9;
  logic [4:0]  nib5;
  logic [7:0]  corr;
  logic [7:0]  off_u;
  logic [16:0] w17;
  logic [12:0] w13;
  logic [4:0]  o5;
  logic [8:0]  o9;

  always_comb begin
    cin    = ((op == OP_ADC) || (op == OP_SBC)) ? flags_in[FLAG_C] : 1'b0;
    is_sub = (op == OP_SUB) || (op == OP_SBC) || (op == OP_CP);
    if (is_sub) begin
      sum9 = {1'b0, acc} - {1'b0, operand} - {8'd0, cin};
      nib5 = {1'b0, acc[3:0]} - {1'b0, operand[3:0]} - {4'd0, cin};
    end else begin
      sum9 = {1'b0, acc} + {1'b0, operand} + {8'd0, cin};
      nib5 = {1'b0, acc[3:0]} + {1'b0, operand[3:0]} + {4'd0, cin};
    end

    // decimal adjust
    corr = 8'd0;
    if (!flags_in[FLAG_N]) begin
      if (flags_in[FLAG_C] || (acc > DAA_LIMIT)) corr = corr | DAA_HI_CORR;
      if (flags_in[FLAG_H] || (acc[3:0] > BCD_MAX)) corr = corr | DAA_LO_CORR;
      s_next.dr = acc + corr;
      s_next.dc = flags_in[FLAG_C] || (acc > DAA_LIMIT);
    end else begin
      if (flags_in[FLAG_C]) corr = corr | DAA_HI_CORR;
      if (flags_in[FLAG_H]) corr = corr | DAA_LO_CORR;
      s_next.dr = acc - corr;
      s_next.dc = flags_in[FLAG_C];
    end

    // 16-bit adds
    off_u = offset;
    if (op == OP_ADD_OFF) begin
      w17 = {1'b0, wide_a} + {1'b0, {8{off_u[7]}}, off_u};
      o5  = {1'b0, wide_a[3:0]} + {1'b0, off_u[3:0]};
      o9  = {1'b0, wide_a[7:0]} + {1'b0, off_u};
      w13 = 13'd0;
      s_next.wh = o5[4];
      s_next.wc = o9[8];
    end else begin
      w17 = {1'b0, wide_a} + {1'b0, wide_b};
      w13 = {1'b0, wide_a[11:0]} + {1'b0, wide_b[11:0]};
      o5  = 5'd0;
      o9  = 9'd0;
      s_next.wh = w13[12];
      s_next.wc = w17[16];
    end
    s_next.w = w17[15:0];

    s_next.op        = op;
    s_next.acc       = acc;
    s_next.operand   = operand;
    s_next.bit_index = bit_index;
    s_next.flags     = flags_in;
    s_next.ar        = sum9[7:0];
    s_next.ac        = sum9[8];
    s_next.ah        = nib5[4];
    if (op == OP_DEC) begin
      s_next.ir = operand - 8'd1;
      s_next.ih = (operand[3:0] == 4'h0);
    end else begin
      s_next.ir = operand + 8'd1;
      s_next.ih = (operand[3:0] == 4'hF);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= s_next;
  end

endmodule

// File: hw/rtl/ebalu_select.sv
module ebalu_select
  import ebalu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  s1_t  in_data,
  output logic out_valid,
  output s2_t  out_data
);

  s2_t        s_next;
  logic [7:0] x;
  logic [7:0] sr;
  logic       sc;
  logic [7:0] mask;
  logic       cin;

  always_comb begin
    cin  = in_data.flags[FLAG_C];
    x    = (in_data.op >= OP_RLCA) ? in_data.acc : in_data.operand;
    mask = 8'd1 << in_data.bit_index;

    case (in_data.op)
      OP_RLC, OP_RLCA: begin
        sr = {x[6:0], x[7]};
        sc = x[7];
      end
      OP_RRC, OP_RRCA: begin
        sr = {x[0], x[7:1]};
        sc = x[0];
      end
      OP_RL, OP_RLA: begin
        sr = {x[6:0], cin};
        sc = x[7];
      end
      OP_RR, OP_RRA: begin
        sr = {cin, x[7:1]};
        sc = x[0];
      end
      OP_SLA: begin
        sr = {x[6:0], 1'b0};
        sc = x[7];
      end
      OP_SRA: begin
        sr = {x[7], x[7:1]};
        sc = x[0];
      end
      OP_SWAP: begin
        sr = {x[3:0], x[7:4]};
        sc = 1'b0;
      end
      OP_SRL: begin
        sr = {1'b0, x[7:1]};
        sc = x[0];
      end
      default: begin
        sr = x;
        sc = 1'b0;
      end
    endcase

    s_next.r     = in_data.acc;
    s_next.w     = 16'd0;
    s_next.zsrc  = in_data.ar;
    s_next.zcalc = 1'b0;
    s_next.zfix  = in_data.flags[FLAG_Z];
    s_next.n     = in_data.flags[FLAG_N];
    s_next.h     = in_data.flags[FLAG_H];
    s_next.c     = cin;

    case (in_data.op)
      OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_CP: begin
        if (in_data.op != OP_CP) s_next.r = in_data.ar;
        s_next.zcalc = 1'b1;
        s_next.n     = (in_data.op != OP_ADD) && (in_data.op != OP_ADC);
        s_next.h     = in_data.ah;
        s_next.c     = in_data.ac;
      end
      OP_AND, OP_XOR, OP_OR: begin
        if (in_data.op == OP_AND) begin
          s_next.r = in_data.acc & in_data.operand;
        end else if (in_data.op == OP_XOR) begin
          s_next.r = in_data.acc ^ in_data.operand;
        end else begin
          s_next.r = in_data.acc | in_data.operand;
        end
        s_next.zsrc  = s_next.r;
        s_next.zcalc = 1'b1;
        s_next.n     = 1'b0;
        s_next.h     = (in_data.op == OP_AND);
        s_next.c     = 1'b0;
      end
      OP_INC, OP_DEC: begin
        s_next.r     = in_data.ir;
        s_next.zsrc  = in_data.ir;
        s_next.zcalc = 1'b1;
        s_next.n     = (in_data.op == OP_DEC);
        s_next.h     = in_data.ih;
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
        s_next.r     = sr;
        s_next.zsrc  = sr;
        s_next.zcalc = 1'b1;
        s_next.n     = 1'b0;
        s_next.h     = 1'b0;
        s_next.c     = sc;
      end
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
        s_next.r    = sr;
        s_next.zfix = 1'b0;
        s_next.n    = 1'b0;
        s_next.h    = 1'b0;
        s_next.c    = sc;
      end
      OP_BIT: begin
        s_next.r    = in_data.operand;
        s_next.zfix = ~|(in_data.operand & mask);
        s_next.n    = 1'b0;
        s_next.h    = 1'b1;
      end
      OP_RES: s_next.r = in_data.operand & ~mask;
      OP_SET: s_next.r = in_data.operand | mask;
      OP_DAA: begin
        s_next.r     = in_data.dr;
        s_next.zsrc  = in_data.dr;
        s_next.zcalc = 1'b1;
        s_next.h     = 1'b0;
        s_next.c     = in_data.dc;
      end
      OP_CPL: begin
        s_next.r = ~in_data.acc;
        s_next.n = 1'b1;
        s_next.h = 1'b1;
      end
      OP_SCF, OP_CCF: begin
        s_next.n = 1'b0;
        s_next.h = 1'b0;
        s_next.c = (in_data.op == OP_SCF) ? 1'b1 : ~cin;
      end
      OP_ADD16, OP_ADD_OFF: begin
        s_next.w = in_data.w;
        if (in_data.op == OP_ADD_OFF) s_next.zfix = 1'b0;
        s_next.n = 1'b0;
        s_next.h = in_data.wh;
        s_next.c = in_data.wc;
      end
      default: begin
        s_next.r = in_data.acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= s_next;
  end

endmodule

// File: hw/rtl/ebalu_flags.sv
module ebalu_flags
  import ebalu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  s2_t         in_data,
  output logic        out_valid,
  output logic [7:0]  result,
  output logic [15:0] wide_result,
  output logic [3:0]  flags_out
);

  logic       z;
  logic [3:0] f_next;

  always_comb begin
    z = in_data.zcalc ? (in_data.zsrc == 8'd0) : in_data.zfix;
    f_next = 4'd0;
    f_next[FLAG_Z] = z;
    f_next[FLAG_N] = in_data.n;
    f_next[FLAG_H] = in_data.h;
    f_next[FLAG_C] = in_data.c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    result      <= in_data.r;
    wide_result <= in_data.w;
    flags_out   <= f_next;
  end

endmodule

// File: bench/eight_bit_alu_with_flags_test.sv
module eight_bit_alu_with_flags_test;
  import ebalu_pkg::*;

  localparam logic [4:0] OP_UNUSED = 5'd31;
  localparam int CYCLE_LIMIT = 100000;
  localparam int RANDOM_REQUESTS = 1815;

  typedef struct {
    logic [7:0]  result;
    logic [15:0] wide;
    logic [3:0]  flags;
  } alu_out_t;

  class alu_scoreboard;
    alu_out_t expected_results[$];
    int mismatches = 0;

    function alu_out_t predict_alu(logic [4:0] o, logic [7:0] a, logic [7:0] v,
                                   logic [2:0] bi, logic [3:0] f, logic [15:0] wa,
                                   logic [15:0] wb, logic [7:0] off);
      alu_out_t p;
      logic [7:0]  r, t, x, corr;
      logic [15:0] w;
      logic [3:0]  nf;
      logic [8:0]  sum9;
      logic [4:0]  nib;
      logic [16:0] sum17;
      logic [12:0] sum13;
      logic        cin, c;
      cin = f[FLAG_C];
      r = a;
      w = 16'h0000;
      nf = f;
      case (o)
        OP_ADD, OP_ADC: begin
          c = (o == OP_ADC) && cin;
          sum9 = a + v + c;
          nib = a[3:0] + v[3:0] + c;
          r = sum9[7:0];
          nf = {r == 8'h00, 1'b0, nib[4], sum9[8]};
        end
        OP_SUB, OP_SBC, OP_CP: begin
          c = (o == OP_SBC) && cin;
          // bit 8 and bit 4 hold the borrows
          sum9 = {1'b0, a} - {1'b0, v} - c;
          nib = {1'b0, a[3:0]} - {1'b0, v[3:0]} - c;
          t = sum9[7:0];
          nf = {t == 8'h00, 1'b1, nib[4], sum9[8]};
          r = (o == OP_CP) ? a : t;
        end
        OP_AND: begin
          r = a & v;
          nf = {r == 8'h00, 1'b0, 1'b1, 1'b0};
        end
        OP_XOR: begin
          r = a ^ v;
          nf = {r == 8'h00, 3'b000};
        end
        OP_OR: begin
          r = a | v;
          nf = {r == 8'h00, 3'b000};
        end
        OP_INC: begin
          r = v + 8'd1;
          nf = {r == 8'h00, 1'b0, v[3:0] == 4'hf, cin};
        end
        OP_DEC: begin
          r = v - 8'd1;
          nf = {r == 8'h00, 1'b1, v[3:0] == 4'h0, cin};
        end
        OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL,
        OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
          x = (o >= OP_RLCA) ? a : v;
          c = 1'b0;
          case (o)
            OP_RLC, OP_RLCA: begin c = x[7]; r = {x[6:0], x[7]}; end
            OP_RRC, OP_RRCA: begin c = x[0]; r = {x[0], x[7:1]}; end
            OP_RL, OP_RLA:   begin c = x[7]; r = {x[6:0], cin}; end
            OP_RR, OP_RRA:   begin c = x[0]; r = {cin, x[7:1]}; end
            OP_SLA:          begin c = x[7]; r = {x[6:0], 1'b0}; end
            OP_SRA:          begin c = x[0]; r = {x[7], x[7:1]}; end
            OP_SWAP:         begin c = 1'b0; r = {x[3:0], x[7:4]}; end
            default:         begin c = x[0]; r = {1'b0, x[7:1]}; end
          endcase
          // accumulator rotates always clear z
          nf = {(o < OP_RLCA) && (r == 8'h00), 2'b00, c};
        end
        OP_BIT: begin
          r = v;
          nf = {~v[bi], 1'b0, 1'b1, cin};
        end
        OP_RES: r = v & ~(8'd1 << bi);
        OP_SET: r = v | (8'd1 << bi);
        OP_DAA: begin
          corr = 8'h00;
          nf = {1'b0, f[FLAG_N], 1'b0, cin};
          if (!f[FLAG_N]) begin
            if (cin || a > 8'h99) begin
              corr = corr | 8'h60;
              nf[FLAG_C] = 1'b1;
            end
            if (f[FLAG_H] || a[3:0] > 4'd9) corr = corr | 8'h06;
            r = a + corr;
          end else begin
            if (cin) corr = corr | 8'h60;
            if (f[FLAG_H]) corr = corr | 8'h06;
            r = a - corr;
          end
          nf[FLAG_Z] = (r == 8'h00);
        end
        OP_CPL: begin
          r = ~a;
          nf = {f[FLAG_Z], 1'b1, 1'b1, cin};
        end
        OP_SCF: nf = {f[FLAG_Z], 2'b00, 1'b1};
        OP_CCF: nf = {f[FLAG_Z], 2'b00, ~cin};
        OP_ADD16: begin
          sum17 = wa + wb;
          sum13 = wa[11:0] + wb[11:0];
          w = sum17[15:0];
          nf = {f[FLAG_Z], 1'b0, sum13[12], sum17[16]};
        end
        OP_ADD_OFF: begin
          w = wa + {{8{off[7]}}, off};
          // h and c come from the unsigned low byte sum
          nib = wa[3:0] + off[3:0];
          sum9 = wa[7:0] + off;
          nf = {2'b00, nib[4], sum9[8]};
        end
        default: ;
      endcase
      p.result = r;
      p.wide = w;
      p.flags = nf;
      return p;
    endfunction

    function void note_request(logic [4:0] o, logic [7:0] a, logic [7:0] v,
                               logic [2:0] bi, logic [3:0] f, logic [15:0] wa,
                               logic [15:0] wb, logic [7:0] off);
      expected_results.push_back(predict_alu(o, a, v, bi, f, wa, wb, off));
    endfunction

    function void check_result(logic [7:0] r, logic [15:0] w, logic [3:0] f);
      alu_out_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: result %h wide %h flags %b", r, w, f);
        return;
      end
      want = expected_results.pop_front();
      if (r !== want.result || w !== want.wide || f !== want.flags) begin
        mismatches++;
        if (mismatches <= 10)
          $display("wrong result: expected result %h wide %h flags %b, got %h %h %b",
                   want.result, want.wide, want.flags, r, w, f);
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [4:0]         op = 5'd0;
  logic [7:0]         acc = 8'h00;
  logic [7:0]         operand = 8'h00;
  logic [2:0]         bit_index = 3'd0;
  logic [3:0]         flags_in = 4'h0;
  logic [15:0]        wide_a = 16'h0000;
  logic [15:0]        wide_b = 16'h0000;
  logic signed [7:0]  offset = 8'sh00;
  logic               done;
  logic [7:0]         result;
  logic [15:0]        wide_result;
  logic [3:0]         flags_out;

  alu_scoreboard sb = new();
  int cycle_count = 0;

  eight_bit_alu_with_flags dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .acc(acc),
    .operand(operand),
    .bit_index(bit_index),
    .flags_in(flags_in),
    .wide_a(wide_a),
    .wide_b(wide_b),
    .offset(offset),
    .done(done),
    .result(result),
    .wide_result(wide_result),
    .flags_out(flags_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("eight_bit_alu_with_flags: mismatch");
      $finish;
    end
  end

  // results first, so a request taken at this edge never meets its own result
  always @(posedge clk) begin
    if (!rst) begin
      if (done !== 1'b0) sb.check_result(result, wide_result, flags_out);
      if (start && !busy)
        sb.note_request(op, acc, operand, bit_index, flags_in, wide_a, wide_b, offset);
    end
  end

  task automatic send_request(input logic [4:0] o, input logic [7:0] a,
                              input logic [7:0] v, input logic [2:0] bi,
                              input logic [3:0] f, input logic [15:0] wa,
                              input logic [15:0] wb, input logic [7:0] off);
    start <= 1'b1;
    op <= o;
    acc <= a;
    operand <= v;
    bit_index <= bi;
    flags_in <= f;
    wide_a <= wa;
    wide_b <= wb;
    offset <= off;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic send_random();
    logic [4:0]  o;
    logic [7:0]  a, v;
    logic [15:0] wa;
    o = ($urandom_range(0, 63) == 0) ? OP_UNUSED : 5'($urandom_range(0, 30));
    a = 8'($urandom);
    v = 8'($urandom);
    wa = 16'($urandom);
    case ($urandom_range(0, 7))
      0: v = a;  // equal operands give zero for sub, cp and xor
      1: begin
        a = {8{a[0]}};
        v = {8{v[0]}};
        wa = {16{wa[0]}};
      end
      default: ;
    endcase
    send_request(o, a, v, 3'($urandom), 4'($urandom), wa, 16'($urandom), 8'($urandom));
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    bit burst;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_request(OP_ADD, 8'hff, 8'h01, 3'd0, 4'h0, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_ADC, 8'h0f, 8'h00, 3'd0, 4'h1, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_SUB, 8'h00, 8'h01, 3'd0, 4'h0, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_SBC, 8'h10, 8'h0f, 3'd0, 4'h1, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_AND, 8'hff, 8'h00, 3'd0, 4'hf, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_XOR, 8'ha5, 8'ha5, 3'd0, 4'h0, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_OR, 8'h00, 8'h80, 3'd0, 4'hf, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_CP, 8'h42, 8'h42, 3'd0, 4'h0, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_INC, 8'h00, 8'hff, 3'd0, 4'h1, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_DEC, 8'h00, 8'h00, 3'd0, 4'h0, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_RLC, 8'h00, 8'h80, 3'd0, 4'h0, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_RRC, 8'h00, 8'h01, 3'd0, 4'h0, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_RL, 8'h00, 8'h80, 3'd0, 4'h0, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_RR, 8'h00, 8'h01, 3'd0, 4'h1, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_SLA, 8'h00, 8'h80, 3'd0, 4'h0, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_SRA, 8'h00, 8'h81, 3'd0, 4'h0, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_SWAP, 8'h00, 8'hf0, 3'd0, 4'hf, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_SRL, 8'h00, 8'h01, 3'd0, 4'h0, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_BIT, 8'h00, 8'h7f, 3'd7, 4'h1, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_RES, 8'h00, 8'hff, 3'd0, 4'h5, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_SET, 8'h00, 8'h00, 3'd7, 4'ha, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_RLCA, 8'h80, 8'h00, 3'd0, 4'h0, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_RRCA, 8'h00, 8'h00, 3'd0, 4'hf, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_RLA, 8'h80, 8'h00, 3'd0, 4'h0, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_RRA, 8'h01, 8'h00, 3'd0, 4'h1, 16'h0000, 16'h0000, 8'h00);
    // decimal adjust after an add and after a subtract
    send_request(OP_DAA, 8'h9a, 8'h00, 3'd0, 4'h0, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_DAA, 8'hff, 8'h00, 3'd0, 4'h7, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_CPL, 8'h00, 8'h00, 3'd0, 4'h9, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_SCF, 8'h55, 8'h00, 3'd0, 4'he, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_CCF, 8'haa, 8'h00, 3'd0, 4'h1, 16'h0000, 16'h0000, 8'h00);
    send_request(OP_ADD16, 8'h00, 8'h00, 3'd0, 4'h8, 16'h0fff, 16'h0001, 8'h00);
    send_request(OP_ADD16, 8'h00, 8'h00, 3'd0, 4'h0, 16'hffff, 16'h0001, 8'h00);
    send_request(OP_ADD_OFF, 8'h00, 8'h00, 3'd0, 4'hf, 16'hffff, 16'h0000, 8'hff);
    send_request(OP_ADD_OFF, 8'h00, 8'h00, 3'd0, 4'h0, 16'h0000, 16'h0000, 8'h7f);
    send_request(OP_UNUSED, 8'h3c, 8'hc3, 3'd5, 4'ha, 16'h1234, 16'h5678, 8'h80);

    // sender holds off until the pipeline is empty
    drain_results();

    burst = 1'b0;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 100 == 0) burst = ($urandom_range(0, 2) == 0);
      if (i == RANDOM_REQUESTS / 2) drain_results();
      send_random();
      if (!burst) idle_cycles(pick_gap());
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("eight_bit_alu_with_flags: match");
    end else begin
      $display("eight_bit_alu_with_flags: mismatch");
    end
    $finish;
  end

endmodule
